>>> sv/i2c_master_bit_engine_defines.svh
// Assertion macros for the I2C master bit engine.
// Used by the top level; expects clk and rst_n in scope where they are used.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i2cm assertion failed");
`define I2CM_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("i2cm forbidden condition seen");
`else
`define I2CM_ASSERT(label, prop)
`define I2CM_ASSERT_NEVER(label, expr)
`endif

`endif

>>> sv/i2cm_pkg.sv
// Shared types and constants of the I2C master bit engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int CFG_W            = 10;
    localparam int DELAY_WIDTH_DEF  = 10;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam logic [CFG_W-1:0] PHASE_CYCLES_RST = 10'd69;

    // Command and engine state codes.
    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_RACK  = 3'd5;

    localparam logic [3:0] BYTE_BITS  = 4'd8;
    localparam logic [3:0] WR_SLOTS   = 4'd9;
    localparam logic [1:0] LAST_PHASE = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] wr_data;
        logic       send_nack;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic       ack_ok;
    } out_t;

    // Classified item held in the queue: cmd is OP_IDLE when no command.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] wr_data;
        logic       send_nack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> sv/i2cm_front.sv
// Front end of the I2C master bit engine: accepts input transfers and decodes the kind.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_front
    import i2cm_pkg::*;
(
    input  logic    in_valid,
    output logic    in_ready,
    input  in_t     in_data,
    input  q_stat_t q_stat,
    output logic    push,
    output item_t   push_item
);

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_item.wr_data   = in_data.wr_data;
        push_item.send_nack = in_data.send_nack;
        push_item.sda_in    = in_data.sda_in;
        case (in_data.kind)
            OP_START: push_item.cmd = OP_START;
            OP_STOP:  push_item.cmd = OP_STOP;
            OP_WRITE: push_item.cmd = OP_WRITE;
            OP_READ:  push_item.cmd = OP_READ;
            default:  push_item.cmd = OP_IDLE;
        endcase
    end

endmodule

>>> sv/i2cm_queue.sv
// Short register FIFO between the front end and the bit engine.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      push_item,
    input  logic                       pop,
    output item_t                      head_item,
    output q_stat_t                    q_stat,
    output logic [$clog2(DEPTH+1)-1:0] q_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    item_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_count      = count_reg;

endmodule

>>> sv/i2cm_engine.sv
// Back end of the I2C master bit engine: bus phase sequencer and result register.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [DELAY_WIDTH-1:0] phase_reload,
    input  item_t                  head_item,
    input  q_stat_t                q_stat,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_t                   out_data
);

    logic [2:0]             op_reg, op_next;
    logic [3:0]             bit_reg, bit_next;
    logic [1:0]             step_reg, step_next;
    logic [7:0]             shift_reg, shift_next;
    logic [DELAY_WIDTH-1:0] delay_reg, delay_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic                   ack_reg, ack_next;
    logic [7:0]             rd_reg, rd_next;
    logic                   nack_reg, nack_next;
    logic                   out_valid_reg;
    out_t                   out_reg, out_next;
    logic                   done;

    // The engine steps once per queued item, whenever the result register is free.
    assign pop = !q_stat.empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        op_next    = op_reg;
        bit_next   = bit_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rd_next    = rd_reg;
        nack_next  = nack_reg;
        done       = 1'b0;

        if (op_reg == OP_IDLE)
        begin
            if (head_item.cmd != OP_IDLE)
            begin
                op_next    = head_item.cmd;
                step_next  = '0;
                bit_next   = '0;
                delay_next = phase_reload;
                case (head_item.cmd)
                    OP_START:
                    begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    OP_STOP:
                    begin
                        sda_next = 1'b0;
                        scl_next = 1'b0;
                    end
                    OP_WRITE:
                    begin
                        shift_next = head_item.wr_data;
                        sda_next   = head_item.wr_data[7];
                    end
                    default:
                    begin
                        shift_next = '0;
                        nack_next  = head_item.send_nack;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                    end
                endcase
            end
        end
        else if (delay_reg != '0)
        begin
            delay_next = delay_reg - DELAY_WIDTH'(1);
        end
        else
        begin
            case (op_reg)
                OP_START:
                begin
                    step_next = step_reg + 2'd1;
                    if (step_next == LAST_PHASE)
                    begin
                        done = 1'b1;
                    end
                    else if (step_next == 2'd1)
                    begin
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                OP_STOP:
                begin
                    step_next = step_reg + 2'd1;
                    if (step_next == LAST_PHASE)
                    begin
                        done = 1'b1;
                    end
                    else if (step_next == 2'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        sda_next = 1'b1;
                    end
                end
                OP_WRITE:
                begin
                    // The ACK slot samples SDA when leaving its SCL-high phase.
                    if (step_reg == 2'd1 && bit_reg == BYTE_BITS)
                    begin
                        ack_next = !head_item.sda_in;
                    end
                    step_next = step_reg + 2'd1;
                    if (step_next == LAST_PHASE)
                    begin
                        step_next  = '0;
                        bit_next   = bit_reg + 4'd1;
                        shift_next = {shift_reg[6:0], 1'b0};
                    end
                    if (bit_next >= WR_SLOTS)
                    begin
                        done = 1'b1;
                    end
                    else if (step_next == 2'd0)
                    begin
                        sda_next = (bit_next >= BYTE_BITS) ? 1'b1 : shift_next[7];
                    end
                    else if (step_next == 2'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                OP_READ:
                begin
                    if (step_reg == 2'd0)
                    begin
                        shift_next = {shift_reg[6:0], head_item.sda_in};
                        step_next  = 2'd1;
                        scl_next   = 1'b0;
                    end
                    else
                    begin
                        bit_next  = bit_reg + 4'd1;
                        step_next = '0;
                        if (bit_next >= BYTE_BITS)
                        begin
                            op_next  = OP_RACK;
                            bit_next = '0;
                            sda_next = nack_reg;
                        end
                        else
                        begin
                            scl_next = 1'b1;
                        end
                    end
                end
                OP_RACK:
                begin
                    step_next = step_reg + 2'd1;
                    if (step_next == LAST_PHASE)
                    begin
                        sda_next = 1'b1;
                        rd_next  = shift_reg;
                        done     = 1'b1;
                    end
                    else
                    begin
                        scl_next = (step_next == 2'd1);
                    end
                end
                default:
                begin
                    op_next   = OP_IDLE;
                    step_next = '0;
                    bit_next  = '0;
                end
            endcase

            if (done)
            begin
                op_next   = OP_IDLE;
                step_next = '0;
                bit_next  = '0;
            end
            else if (op_reg == OP_START || op_reg == OP_STOP || op_reg == OP_WRITE
                     || op_reg == OP_READ || op_reg == OP_RACK)
            begin
                delay_next = phase_reload;
            end
        end

        out_next.scl_release = scl_next;
        out_next.sda_release = sda_next;
        out_next.busy_res    = (op_next != OP_IDLE);
        out_next.done_res    = done;
        out_next.rd_data     = rd_next;
        out_next.ack_ok      = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_IDLE;
            bit_reg       <= '0;
            step_reg      <= '0;
            shift_reg     <= '0;
            delay_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
            rd_reg        <= '0;
            nack_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                op_reg    <= op_next;
                bit_reg   <= bit_next;
                step_reg  <= step_next;
                shift_reg <= shift_next;
                delay_reg <= delay_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                ack_reg   <= ack_next;
                rd_reg    <= rd_next;
                nack_reg  <= nack_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> sv/i2c_master_bit_engine.sv
// I2C master bit engine, one input transfer per clock and one result transfer for each input.
// Every accepted input is a bus clock sample (optional command plus the SDA level) and its
// result carries the SCL/SDA drive levels after that sample, with busy and done flags, the
// last read byte and the last write's ACK. The block sustains one transfer per clock while
// results are taken: the front end decodes the kind and writes a two-entry queue, and the
// phase sequencer takes one queued item per clock into its result register. A result follows
// its input through the queue and the result register, and inputs keep flowing into the
// queue while a result waits to be taken, until the queue is full. Each bus phase lasts
// phase_cycles input samples (0 counts as 1, values past the DELAY_WIDTH range saturate).
// Commands that arrive while a command is in progress, and unknown kinds, are ignored.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue, i2cm_engine and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_defines.svh"

module i2c_master_bit_engine
    import i2cm_pkg::*;
#(
    parameter int DELAY_WIDTH = DELAY_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data
);

    // Width that holds both the register value and the largest phase count.
    localparam int PCW = (DELAY_WIDTH > CFG_W) ? DELAY_WIDTH : CFG_W;
    localparam logic [PCW-1:0] DELAY_MAX = PCW'((1 << DELAY_WIDTH) - 1);

    logic [CFG_W-1:0]                 phase_cycles_reg;
    logic [PCW-1:0]                   phase_ext;
    logic [PCW-1:0]                   phase_sat;
    logic [DELAY_WIDTH-1:0]           phase_reload;
    logic                             push;
    logic                             pop;
    item_t                            push_item;
    item_t                            head_item;
    q_stat_t                          q_stat;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    // Phase length register: the user must write it only while the engine is idle, unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_cycles_reg <= PHASE_CYCLES_RST;
        end
        else if (cfg_we)
        begin
            phase_cycles_reg <= cfg_wdata;
        end
    end

    // The delay counter is loaded with the phase length minus one.
    always_comb
    begin
        phase_ext = PCW'(phase_cycles_reg);
        if (phase_ext == '0)
        begin
            phase_sat = PCW'(1);
        end
        else if (phase_ext > DELAY_MAX)
        begin
            phase_sat = DELAY_MAX;
        end
        else
        begin
            phase_sat = phase_ext;
        end
        phase_reload = DELAY_WIDTH'(phase_sat - PCW'(1));
    end

    i2cm_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat),
        .q_count   (q_count)
    );

    i2cm_engine #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .phase_reload (phase_reload),
        .head_item    (head_item),
        .q_stat       (q_stat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    // An accepted transfer is held either in the queue or in the result register.
    `I2CM_ASSERT(a_accept_lands, push |=> (q_count != '0) || out_valid)
    // The sequencer never takes an item from an empty queue.
    `I2CM_ASSERT_NEVER(a_pop_from_empty, pop && (q_count == '0))
    // A completing command has already left the busy state in the same result.
    `I2CM_ASSERT(a_done_not_busy, out_valid && out_data.done_res |-> !out_data.busy_res)

endmodule

>>> tb/tb.sv
// Self-checking testbench for the I2C master bit engine: directed rows, then random bus traffic.
// Depends on i2cm_pkg and i2c_master_bit_engine only; no files, arguments or other modules.
`timescale 1ns / 1ps

module tb;
    import i2cm_pkg::*;

    // Input kinds that the engine must ignore.
    localparam logic [2:0] KIND_UNUSED5 = 3'd5;
    localparam logic [2:0] KIND_UNUSED6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED7 = 3'd7;

    // How a directed row drives the sampled SDA line.
    localparam logic [1:0] SDA_LOW  = 2'd0;
    localparam logic [1:0] SDA_HIGH = 2'd1;
    localparam logic [1:0] SDA_RAND = 2'd2;

    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 5000;
    localparam int SHOW_LIMIT   = 200;
    localparam int BLOCK_ITEMS  = 40;

    typedef struct packed {
        logic       set_phase;
        logic [9:0] phase;
        logic [2:0] kind;
        logic [7:0] wr_data;
        logic       send_nack;
        logic [1:0] sda_mode;
        logic       typed;
        out_t       want;
    } bus_row_t;

    localparam out_t IDLE_LEVELS  = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
    localparam out_t START_LEVELS = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
    localparam out_t NO_LEVELS    = '0;

    localparam int DIR_ROWS = 18;

    // Each row is one command; the rest of the command is played out with filler transfers.
    localparam bus_row_t DIRECTED [DIR_ROWS] = '{
        '{1'b0, 10'd0,    OP_IDLE,      8'h00, 1'b0, SDA_HIGH, 1'b1, IDLE_LEVELS},
        '{1'b0, 10'd0,    KIND_UNUSED5, 8'hFF, 1'b1, SDA_LOW,  1'b1, IDLE_LEVELS},
        '{1'b0, 10'd0,    KIND_UNUSED6, 8'hFF, 1'b1, SDA_LOW,  1'b1, IDLE_LEVELS},
        '{1'b0, 10'd0,    KIND_UNUSED7, 8'hFF, 1'b1, SDA_LOW,  1'b1, IDLE_LEVELS},
        '{1'b0, 10'd0,    OP_START,     8'h00, 1'b0, SDA_RAND, 1'b1, START_LEVELS},
        '{1'b1, 10'd0,    OP_STOP,      8'h00, 1'b0, SDA_RAND, 1'b0, NO_LEVELS},
        '{1'b1, 10'd1,    OP_WRITE,     8'hFF, 1'b0, SDA_LOW,  1'b0, NO_LEVELS},
        '{1'b0, 10'd0,    OP_WRITE,     8'h00, 1'b1, SDA_HIGH, 1'b0, NO_LEVELS},
        '{1'b0, 10'd0,    OP_WRITE,     8'hA5, 1'b0, SDA_RAND, 1'b0, NO_LEVELS},
        '{1'b0, 10'd0,    OP_READ,      8'h00, 1'b0, SDA_HIGH, 1'b0, NO_LEVELS},
        '{1'b0, 10'd0,    OP_READ,      8'hFF, 1'b1, SDA_LOW,  1'b0, NO_LEVELS},
        '{1'b0, 10'd0,    OP_READ,      8'h3C, 1'b1, SDA_RAND, 1'b0, NO_LEVELS},
        '{1'b0, 10'd0,    OP_STOP,      8'h00, 1'b0, SDA_RAND, 1'b0, NO_LEVELS},
        '{1'b1, 10'd2,    OP_START,     8'h00, 1'b0, SDA_RAND, 1'b0, NO_LEVELS},
        '{1'b0, 10'd0,    OP_WRITE,     8'h5A, 1'b1, SDA_RAND, 1'b0, NO_LEVELS},
        '{1'b0, 10'd0,    OP_READ,      8'hC3, 1'b0, SDA_RAND, 1'b0, NO_LEVELS},
        '{1'b0, 10'd0,    OP_STOP,      8'h00, 1'b0, SDA_RAND, 1'b0, NO_LEVELS},
        '{1'b1, 10'd5,    OP_START,     8'h00, 1'b0, SDA_RAND, 1'b0, NO_LEVELS}
    };

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    in_t              in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_t             out_data;

    // Bus levels the engine should report, oldest first.
    out_t       expected_bus [$];
    logic [2:0] cmd_plan [$];

    int   send_gap_pct = 27;
    int   take_gap_pct = 85;
    int   mismatches   = 0;
    logic hold_request = 1'b0;
    logic hold_taken   = 1'b0;
    int   hold_left    = 0;
    int   stall_run    = 0;

    // Predictor state: one copy of the engine registers and the phase length register.
    logic [2:0]       eng_state;
    int               eng_bit;
    int               eng_phase;
    logic [7:0]       eng_shift;
    int               eng_wait;
    logic             scl_lvl;
    logic             sda_lvl;
    logic             ack_lvl;
    logic [7:0]       rd_last;
    logic             nack_hold;
    logic [CFG_W-1:0] phase_len_reg;

    i2c_master_bit_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // A zero length counts as one; the 10-bit register never exceeds the counter range.
    function automatic int phase_len();
        return (phase_len_reg == '0) ? 1 : int'(phase_len_reg);
    endfunction

    // Advances the engine by one clock sample and returns the bus levels after it.
    function automatic out_t engine_step(in_t item);
        out_t levels;
        logic done;
        done = 1'b0;
        if (eng_state == OP_IDLE)
        begin
            if (item.kind >= OP_START && item.kind <= OP_READ)
            begin
                eng_state = item.kind;
                eng_phase = 0;
                eng_bit   = 0;
                eng_wait  = phase_len() - 1;
                case (item.kind)
                    OP_START:
                    begin
                        sda_lvl = 1'b1;
                        scl_lvl = 1'b1;
                    end
                    OP_STOP:
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = 1'b0;
                    end
                    OP_WRITE:
                    begin
                        eng_shift = item.wr_data;
                        sda_lvl   = item.wr_data[7];
                    end
                    default:
                    begin
                        eng_shift = '0;
                        nack_hold = item.send_nack;
                        sda_lvl   = 1'b1;
                        scl_lvl   = 1'b1;
                    end
                endcase
            end
        end
        else if (eng_wait > 0)
        begin
            eng_wait--;
        end
        else
        begin
            // The current phase is over: move to the next one.
            case (eng_state)
                OP_START:
                begin
                    eng_phase++;
                    if (eng_phase >= LAST_PHASE) done = 1'b1;
                    else if (eng_phase == 1) sda_lvl = 1'b0;
                    else scl_lvl = 1'b0;
                end
                OP_STOP:
                begin
                    eng_phase++;
                    if (eng_phase >= LAST_PHASE) done = 1'b1;
                    else if (eng_phase == 1) scl_lvl = 1'b1;
                    else sda_lvl = 1'b1;
                end
                OP_WRITE:
                begin
                    // The slave's ACK is taken when the ninth SCL-high phase ends.
                    if (eng_phase == 1 && eng_bit == BYTE_BITS) ack_lvl = ~item.sda_in;
                    eng_phase++;
                    if (eng_phase >= LAST_PHASE)
                    begin
                        eng_phase = 0;
                        eng_bit++;
                        if (eng_bit >= WR_SLOTS) done = 1'b1;
                        else eng_shift = eng_shift << 1;
                    end
                    if (!done)
                    begin
                        if (eng_phase == 0)
                            sda_lvl = (eng_bit >= BYTE_BITS) ? 1'b1 : eng_shift[7];
                        else
                            scl_lvl = (eng_phase == 1);
                    end
                end
                OP_READ:
                begin
                    if (eng_phase == 0)
                    begin
                        eng_shift = {eng_shift[6:0], item.sda_in};
                        eng_phase = 1;
                        scl_lvl   = 1'b0;
                    end
                    else
                    begin
                        eng_bit++;
                        eng_phase = 0;
                        if (eng_bit >= BYTE_BITS)
                        begin
                            eng_state = OP_RACK;
                            eng_bit   = 0;
                            sda_lvl   = nack_hold;
                        end
                        else
                        begin
                            scl_lvl = 1'b1;
                        end
                    end
                end
                OP_RACK:
                begin
                    eng_phase++;
                    if (eng_phase >= LAST_PHASE)
                    begin
                        sda_lvl = 1'b1;
                        rd_last = eng_shift;
                        done    = 1'b1;
                    end
                    else
                    begin
                        scl_lvl = (eng_phase == 1);
                    end
                end
                default:
                begin
                    eng_state = OP_IDLE;
                    eng_phase = 0;
                    eng_bit   = 0;
                end
            endcase
            if (done)
            begin
                eng_state = OP_IDLE;
                eng_phase = 0;
                eng_bit   = 0;
            end
            else
            begin
                eng_wait = phase_len() - 1;
            end
        end
        levels.scl_release = scl_lvl;
        levels.sda_release = sda_lvl;
        levels.busy_res    = (eng_state != OP_IDLE);
        levels.done_res    = done;
        levels.rd_data     = rd_last;
        levels.ack_ok      = ack_lvl;
        return levels;
    endfunction

    function automatic logic sda_for(logic [1:0] mode);
        return (mode == SDA_RAND) ? 1'($urandom) : (mode == SDA_HIGH);
    endfunction

    // Offers one transfer, waits for it to be taken, then records what the engine must report.
    task automatic send_item(in_t item, logic typed, out_t want);
        out_t levels;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        levels = engine_step(item);
        expected_bus.push_back(typed ? want : levels);
    endtask

    // Stops offering transfers and waits until every expected result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_bus.size() != 0) @(posedge clk);
    endtask

    task automatic write_phase(logic [CFG_W-1:0] value);
        drain();
        cfg_we        <= 1'b1;
        cfg_wdata     <= value;
        phase_len_reg  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result side: checks each transfer, then decides ready for the next cycle.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bus.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
            end
            else
            begin
                want = expected_bus.pop_front();
                compare_field("scl_release", want.scl_release, out_data.scl_release);
                compare_field("sda_release", want.sda_release, out_data.sda_release);
                compare_field("busy_res", want.busy_res, out_data.busy_res);
                compare_field("done_res", want.done_res, out_data.done_res);
                compare_field("rd_data", want.rd_data, out_data.rd_data);
                compare_field("ack_ok", want.ack_ok, out_data.ack_ok);
            end
        end
        if (hold_request != hold_taken)
        begin
            hold_taken = hold_request;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= take_gap_pct);
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means the engine hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_run = 0;
        else
            stall_run++;
        if (stall_run >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        bus_row_t row;
        in_t      item;
        int       amount;
        int       count;
        eng_state     = OP_IDLE;
        eng_bit       = 0;
        eng_phase     = 0;
        eng_shift     = '0;
        eng_wait      = 0;
        scl_lvl       = 1'b1;
        sda_lvl       = 1'b1;
        ack_lvl       = 1'b0;
        rd_last       = '0;
        nack_hold     = 1'b0;
        phase_len_reg = PHASE_CYCLES_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; commands arriving while busy are mixed into the filler.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = DIRECTED[r];
            if (row.set_phase) write_phase(row.phase);
            item = '{row.kind, row.wr_data, row.send_nack, sda_for(row.sda_mode)};
            send_item(item, row.typed, row.want);
            while (eng_state != OP_IDLE)
            begin
                item.kind      = ($urandom_range(0, 3) == 0) ?
                                 3'($urandom_range(OP_START, KIND_UNUSED7)) : OP_IDLE;
                item.wr_data   = 8'($urandom);
                item.send_nack = 1'($urandom);
                item.sda_in    = sda_for(row.sda_mode);
                send_item(item, 1'b0, NO_LEVELS);
            end
        end

        // Random bus traffic in three idling regimes, a few phase lengths in each.
        for (int k = 0; k < 3; k++)
        begin
            for (int blk = 0; blk < 4; blk++)
            begin
                write_phase(CFG_W'($urandom_range(0, 4)));
                send_gap_pct = (k == 0) ? 27 : (k == 1) ? 85 : 0;
                take_gap_pct = (k == 0) ? 85 : (k == 1) ? 27 : 0;
                // Starve the result side once per regime so the input side backs up.
                if (blk == 0) hold_request = ~hold_request;
                count = 0;
                while (count < BLOCK_ITEMS || eng_state != OP_IDLE)
                begin
                    item.wr_data   = 8'($urandom);
                    item.send_nack = 1'($urandom);
                    item.sda_in    = 1'($urandom);
                    if (eng_state != OP_IDLE)
                    begin
                        item.kind = ($urandom_range(0, 7) == 0) ?
                                    3'($urandom_range(OP_START, KIND_UNUSED7)) : OP_IDLE;
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        item.kind = OP_IDLE;
                    end
                    else
                    begin
                        if (cmd_plan.size() == 0)
                        begin
                            // Mostly whole transactions, sometimes without the closing stop,
                            // and now and then a lone random kind.
                            if ($urandom_range(0, 9) < 8)
                            begin
                                cmd_plan.push_back(OP_START);
                                amount = $urandom_range(1, 3);
                                repeat (amount)
                                    cmd_plan.push_back($urandom_range(0, 1) ? OP_WRITE : OP_READ);
                                if ($urandom_range(0, 7) != 0) cmd_plan.push_back(OP_STOP);
                            end
                            else
                            begin
                                cmd_plan.push_back(3'($urandom_range(OP_IDLE, KIND_UNUSED7)));
                            end
                        end
                        item.kind = cmd_plan.pop_front();
                    end
                    send_item(item, 1'b0, NO_LEVELS);
                    count++;
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_bus.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
